// ===== rtl/core/mrp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared types and constants for the Miller-Rabin prime test block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrp_pkg;

    localparam int unsigned FIELD_WIDTH = 32;

    // verdict codes
    localparam logic [1:0] VERDICT_PASS    = 2'd0;
    localparam logic [1:0] VERDICT_TWO     = 2'd1;
    localparam logic [1:0] VERDICT_TRIVIAL = 2'd2;
    localparam logic [1:0] VERDICT_WITNESS = 2'd3;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] candidate;
        logic [FIELD_WIDTH-1:0] base;
        logic                   last_of_group;
    } item_t;

    typedef struct packed {
        logic [1:0] verdict_code;
        logic       base_is_witness;
        logic       group_done;
        logic       probable_prime;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPLIT,
        S_RED,
        S_POW,
        S_MACC,
        S_MSQ,
        S_CHK,
        S_SQX
    } state_t;

    // operand selection for the modular multiplier
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_ACC,
        OP_SQ,
        OP_X
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    shift_d;
        logic    inc_b;
        logic    inc_i;
        logic    mul_start;
        mul_op_t mul_op;
        logic    wr_acc;
        logic    wr_sq;
    } cmd_t;

    typedef struct packed {
        logic in_two;
        logic in_trivial;
        logic d_lsb;
        logic d_zero;
        logic mul_done;
        logic acc_one;
        logic acc_nm1;
        logic i_zero;
        logic i_is_b;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mrp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mrp_mulmod
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
// Requires x < n and n >= 3. Result valid on the done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module mrp_mulmod #(
    parameter int unsigned NUM_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [NUM_WIDTH-1:0] x,
    input  wire logic [NUM_WIDTH-1:0] y,
    input  wire logic [NUM_WIDTH-1:0] n,
    output logic                      done,
    output logic [NUM_WIDTH-1:0]      prod
);

    localparam int unsigned CW = $clog2(NUM_WIDTH);

    logic [NUM_WIDTH-1:0] acc_reg, acc_next;
    logic [NUM_WIDTH-1:0] x_reg;
    logic [NUM_WIDTH-1:0] y_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 run_reg;
    logic                 done_reg;

    logic [NUM_WIDTH:0] dbl, red1, sum, red2;

    // double and reduce, then add and reduce
    always_comb
    begin
        dbl  = {acc_reg, 1'b0};
        red1 = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
        sum  = {1'b0, red1[NUM_WIDTH-1:0]} +
               (y_reg[NUM_WIDTH-1] ? {1'b0, x_reg} : '0);
        red2 = (sum >= {1'b0, n}) ? sum - {1'b0, n} : sum;
        acc_next = red2[NUM_WIDTH-1:0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == '0);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NUM_WIDTH - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    run_reg <= 1'b0;
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[NUM_WIDTH-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mrp_datapath.sv =====
// ----------------------------------------------------------------------------
// mrp_datapath
// Holds candidate, exponent, accumulator and square; drives the multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mrp_datapath #(
    parameter int unsigned NUM_WIDTH = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mrp_pkg::item_t item,
    input  wire mrp_pkg::cmd_t  cmd,
    output mrp_pkg::status_t    status
);

    localparam int unsigned BW = $clog2(NUM_WIDTH);

    logic [NUM_WIDTH-1:0] cand_w, base_w;
    logic [NUM_WIDTH-1:0] n_reg, base_reg, d_reg, acc_reg, sq_reg;
    logic [BW-1:0]        b_reg, i_reg;
    logic [NUM_WIDTH-1:0] mx, my, prod;
    logic                 mdone;

    assign cand_w = item.candidate[NUM_WIDTH-1:0];
    assign base_w = item.base[NUM_WIDTH-1:0];

    // multiplier operand select
    always_comb
    begin
        case (cmd.mul_op)
            mrp_pkg::OP_REDUCE: begin mx = NUM_WIDTH'(1); my = base_reg; end
            mrp_pkg::OP_ACC:    begin mx = sq_reg;        my = acc_reg;  end
            mrp_pkg::OP_SQ:     begin mx = sq_reg;        my = sq_reg;   end
            mrp_pkg::OP_X:      begin mx = acc_reg;       my = acc_reg;  end
            default:            begin mx = acc_reg;       my = acc_reg;  end
        endcase
    end

    mrp_mulmod #(.NUM_WIDTH(NUM_WIDTH)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .x     (mx),
        .y     (my),
        .n     (n_reg),
        .done  (mdone),
        .prod  (prod)
    );

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg    <= cand_w;
            base_reg <= base_w;
            d_reg    <= cand_w - 1'b1;
            b_reg    <= '0;
            i_reg    <= '0;
            acc_reg  <= NUM_WIDTH'(1);
        end
        else
        begin
            if (cmd.shift_d)
                d_reg <= d_reg >> 1;
            if (cmd.inc_b)
                b_reg <= b_reg + 1'b1;
            if (cmd.inc_i)
                i_reg <= i_reg + 1'b1;
            if (cmd.wr_acc)
                acc_reg <= prod;
            if (cmd.wr_sq)
                sq_reg <= prod;
        end
    end

    // status
    always_comb
    begin
        status.in_two     = (cand_w == NUM_WIDTH'(2));
        status.in_trivial = !status.in_two &&
                            (!cand_w[0] || (cand_w == NUM_WIDTH'(1)));
        status.d_lsb      = d_reg[0];
        status.d_zero     = (d_reg == '0);
        status.mul_done   = mdone;
        status.acc_one    = (acc_reg == NUM_WIDTH'(1));
        status.acc_nm1    = (acc_reg == n_reg - 1'b1);
        status.i_zero     = (i_reg == '0);
        status.i_is_b     = (i_reg == b_reg);
    end

endmodule

`default_nettype wire

// ===== rtl/core/mrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrp_ctrl
// Sequencer for the test: split, reduce, square-and-multiply, squaring check.
// Also holds the result register and the sticky composite flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mrp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             last_in,
    input  wire mrp_pkg::status_t status,
    output mrp_pkg::cmd_t         cmd,
    output logic                  busy,
    output logic                  result_valid,
    output mrp_pkg::result_t      result
);

    mrp_pkg::state_t  state_reg, state_next;
    logic             last_reg;
    logic             composite_reg;
    logic             valid_reg;
    mrp_pkg::result_t result_reg;

    logic             fin;
    logic [1:0]       fin_code;
    logic             fin_last;
    logic             accept;
    logic             set_comp;

    assign accept = start && (state_reg == mrp_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrp_pkg::S_IDLE:
                if (start && !status.in_two && !status.in_trivial)
                    state_next = mrp_pkg::S_SPLIT;
            mrp_pkg::S_SPLIT:
                if (status.d_lsb)
                    state_next = mrp_pkg::S_RED;
            mrp_pkg::S_RED:
                if (status.mul_done)
                    state_next = mrp_pkg::S_POW;
            mrp_pkg::S_POW:
                if (status.d_zero)
                    state_next = mrp_pkg::S_CHK;
                else if (status.d_lsb)
                    state_next = mrp_pkg::S_MACC;
                else
                    state_next = mrp_pkg::S_MSQ;
            mrp_pkg::S_MACC:
                if (status.mul_done)
                    state_next = mrp_pkg::S_MSQ;
            mrp_pkg::S_MSQ:
                if (status.mul_done)
                    state_next = mrp_pkg::S_POW;
            mrp_pkg::S_CHK:
                if ((status.i_zero && status.acc_one) || status.i_is_b ||
                    status.acc_nm1)
                    state_next = mrp_pkg::S_IDLE;
                else
                    state_next = mrp_pkg::S_SQX;
            mrp_pkg::S_SQX:
                if (status.mul_done)
                    state_next = mrp_pkg::S_CHK;
            default:
                state_next = mrp_pkg::S_IDLE;
        endcase
    end

    // commands and finish detection
    always_comb
    begin
        cmd           = '0;
        cmd.mul_op    = mrp_pkg::OP_REDUCE;
        fin           = 1'b0;
        fin_code      = mrp_pkg::VERDICT_PASS;
        cmd.load      = accept;
        cmd.mul_start = (state_next != state_reg) &&
                        ((state_next == mrp_pkg::S_RED) ||
                         (state_next == mrp_pkg::S_MACC) ||
                         (state_next == mrp_pkg::S_MSQ) ||
                         (state_next == mrp_pkg::S_SQX));
        case (state_next)
            mrp_pkg::S_MACC: cmd.mul_op = mrp_pkg::OP_ACC;
            mrp_pkg::S_MSQ:  cmd.mul_op = mrp_pkg::OP_SQ;
            mrp_pkg::S_SQX:  cmd.mul_op = mrp_pkg::OP_X;
            default:         cmd.mul_op = mrp_pkg::OP_REDUCE;
        endcase
        case (state_reg)
            mrp_pkg::S_IDLE:
                if (start && status.in_two)
                begin
                    fin      = 1'b1;
                    fin_code = mrp_pkg::VERDICT_TWO;
                end
                else if (start && status.in_trivial)
                begin
                    fin      = 1'b1;
                    fin_code = mrp_pkg::VERDICT_TRIVIAL;
                end
            mrp_pkg::S_SPLIT:
                if (!status.d_lsb)
                begin
                    cmd.shift_d = 1'b1;
                    cmd.inc_b   = 1'b1;
                end
            mrp_pkg::S_RED:
                cmd.wr_sq = status.mul_done;
            mrp_pkg::S_MACC:
                cmd.wr_acc = status.mul_done;
            mrp_pkg::S_MSQ:
            begin
                cmd.wr_sq   = status.mul_done;
                cmd.shift_d = status.mul_done;
            end
            // a value of one passes only before the first squaring (i is zero);
            // minus one is looked for before each squaring, not after the last
            mrp_pkg::S_CHK:
                if ((status.i_zero && status.acc_one) ||
                    (status.acc_nm1 && !status.i_is_b))
                begin
                    fin      = 1'b1;
                    fin_code = mrp_pkg::VERDICT_PASS;
                end
                else if (status.i_is_b)
                begin
                    fin      = 1'b1;
                    fin_code = mrp_pkg::VERDICT_WITNESS;
                end
            mrp_pkg::S_SQX:
            begin
                cmd.wr_acc = status.mul_done;
                cmd.inc_i  = status.mul_done;
            end
            default:
                cmd.load = accept;
        endcase
        fin_last = (state_reg == mrp_pkg::S_IDLE) ? last_in : last_reg;
        set_comp = (fin_code == mrp_pkg::VERDICT_TRIVIAL) ||
                   (fin_code == mrp_pkg::VERDICT_WITNESS);
    end

    // state, result register, sticky flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrp_pkg::S_IDLE;
            last_reg      <= 1'b0;
            composite_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= fin;
            if (accept)
                last_reg <= last_in;
            if (fin)
                composite_reg <= fin_last ? 1'b0 : (composite_reg || set_comp);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            result_reg.verdict_code    <= fin_code;
            result_reg.base_is_witness <= (fin_code == mrp_pkg::VERDICT_WITNESS);
            result_reg.group_done      <= fin_last;
            result_reg.probable_prime  <= !(composite_reg || set_comp);
        end
    end

    assign busy         = (state_reg != mrp_pkg::S_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/miller_rabin_prime_test.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_prime_test
// Miller-Rabin test of one candidate against one base per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   An item {candidate, base, last_of_group} is taken when start is high and
//   busy is low. One result {verdict_code, base_is_witness, group_done,
//   probable_prime} appears for one cycle with result_valid high; it must be
//   captured then, the receiver cannot stall it.
//   A candidate of two, or an even or below-two candidate, is answered the
//   cycle after the transfer with busy staying low.
//   Other candidates run on one bit-serial modular multiplier, one product at a
//   time: a reduction of the base, square-and-multiply over d, then up to b
//   extra squarings, where n-1 = d*2^b. The strobe ends the run and busy
//   drops with it. One item at a time.
//   probable_prime covers the whole group so far; the sticky flag clears
//   after an item marked last_of_group. Reset clears the sequencer, the
//   sticky flag and the strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module miller_rabin_prime_test #(
    parameter int unsigned NUM_WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire mrp_pkg::item_t   item,
    output logic                  busy,
    output logic                  result_valid,
    output mrp_pkg::result_t      result
);

    mrp_pkg::cmd_t    cmd;
    mrp_pkg::status_t status;

    mrp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_in      (item.last_of_group),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    mrp_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire

// ===== tb/tb_miller_rabin_prime_test.sv =====
// ----------------------------------------------------------------------------
// tb_miller_rabin_prime_test
// Self-checking bench for the Miller-Rabin prime test block: directed corner
// cases, then grouped random candidates, checked against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_miller_rabin_prime_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned W = 32;

    logic             clk;
    logic             rst_n;
    logic             start;
    mrp_pkg::item_t   item;
    logic             busy;
    logic             result_valid;
    mrp_pkg::result_t result;

    miller_rabin_prime_test #(.NUM_WIDTH(W)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    mrp_pkg::result_t verdict_q[$];
    bit               composite_flag;
    int               errors;
    int               sender_idle_pct;

    // prime list for well-formed candidates
    localparam int unsigned NPRIMES = 12;
    logic [W-1:0] primes [NPRIMES] = '{32'd3, 32'd5, 32'd7, 32'd13, 32'd97, 32'd65537,
        32'd2147483647, 32'd4294967291, 32'd1000003, 32'd7919, 32'd104729, 32'd257};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000ms;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [W-1:0] mulmod(logic [W-1:0] x, logic [W-1:0] y,
                                            logic [W-1:0] n);
        logic [2*W-1:0] p;
        p = {{W{1'b0}}, x} * {{W{1'b0}}, y};
        return W'(p % {{W{1'b0}}, n});
    endfunction

    function automatic bit witness_of(logic [W-1:0] a, logic [W-1:0] n);
        logic [W-1:0] d, acc, sq, x;
        int b;
        d = n - 1;
        b = 0;
        while (d[0] == 1'b0)
        begin
            d = d >> 1;
            b++;
        end
        acc = 1;
        sq = a % n;
        while (d != 0)
        begin
            if (d[0]) acc = mulmod(acc, sq, n);
            sq = mulmod(sq, sq, n);
            d = d >> 1;
        end
        x = acc;
        if (x == 1) return 1'b0;
        for (int i = 0; i < b; i++)
        begin
            if (x == n - 1) return 1'b0;
            x = mulmod(x, x, n);
        end
        return 1'b1;
    endfunction

    // predict the result of one accepted item
    function automatic mrp_pkg::result_t predict_verdict(mrp_pkg::item_t it);
        mrp_pkg::result_t r;
        r = '0;
        if (it.candidate == 2)
        begin
            r.verdict_code = mrp_pkg::VERDICT_TWO;
        end
        else if (it.candidate[0] == 1'b0 || it.candidate < 2)
        begin
            r.verdict_code = mrp_pkg::VERDICT_TRIVIAL;
            composite_flag = 1'b1;
        end
        else
        begin
            r.base_is_witness = witness_of(it.base, it.candidate);
            r.verdict_code = r.base_is_witness ? mrp_pkg::VERDICT_WITNESS
                                               : mrp_pkg::VERDICT_PASS;
            if (r.base_is_witness) composite_flag = 1'b1;
        end
        r.group_done = it.last_of_group;
        r.probable_prime = ~composite_flag;
        if (it.last_of_group) composite_flag = 1'b0;
        return r;
    endfunction

    // send one item; held until the transfer edge, start is then updated
    // at the next falling edge by the next call or by drain
    task automatic send_item(logic [W-1:0] n, logic [W-1:0] a, logic last);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item <= '{candidate: n, base: a, last_of_group: last};
        do @(posedge clk); while (busy);
        verdict_q.push_back(predict_verdict(item));
    endtask

    // compare each result strobe with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                mrp_pkg::result_t e;
                e = verdict_q.pop_front();
                if (e.verdict_code !== result.verdict_code)
                    $display("%0t: verdict_code exp %0d got %0d", $time,
                             e.verdict_code, result.verdict_code);
                if (e.base_is_witness !== result.base_is_witness)
                    $display("%0t: base_is_witness exp %0b got %0b", $time,
                             e.base_is_witness, result.base_is_witness);
                if (e.group_done !== result.group_done)
                    $display("%0t: group_done exp %0b got %0b", $time,
                             e.group_done, result.group_done);
                if (e.probable_prime !== result.probable_prime)
                    $display("%0t: probable_prime exp %0b got %0b", $time,
                             e.probable_prime, result.probable_prime);
                if (e !== result) errors++;
            end
        end
    end

    function automatic logic [W-1:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom_range(255);
            1: return $urandom_range(65535);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_item(32'd2, 32'hFFFF_FFFF, 1'b0);
        send_item(32'd0, 32'd0, 1'b0);
        send_item(32'd1, 32'd5, 1'b1);
        send_item(32'd2, 32'd3, 1'b1);
        send_item(32'hFFFF_FFFE, 32'd7, 1'b1);
        send_item(32'd3, 32'd0, 1'b1);
        send_item(32'd3, 32'd2, 1'b1);
        send_item(32'd4294967291, 32'hFFFF_FFFF, 1'b0);
        send_item(32'd4294967291, 32'd4294967290, 1'b0);
        send_item(32'd4294967291, 32'd1, 1'b1);
        send_item(32'hFFFF_FFFF, 32'd2, 1'b1);
        send_item(32'd341, 32'd2, 1'b0);       // base-2 pseudoprime
        send_item(32'd341, 32'd3, 1'b1);
        send_item(32'd561, 32'd1122, 1'b1);    // base multiple of candidate
        send_item(32'd9, 32'd8, 1'b0);
        send_item(32'd2, 32'd5, 1'b1);         // two after composite in group
        send_item(32'd2147483647, 32'hAAAA_AAAA, 1'b1);
        send_item(32'h5555_5555, 32'h5555_5555, 1'b1);
    endtask

    // groups of bases over one candidate, mostly odd, some broken groups
    task automatic test_random(int groups);
        logic [W-1:0] n;
        int k;
        for (int g = 0; g < groups; g++)
        begin
            case ($urandom_range(9))
                0, 1, 2: n = primes[$urandom_range(NPRIMES-1)];
                3: n = rand_word() & ~32'd1;
                4: n = $urandom_range(3);
                default: n = rand_word() | 32'd1;
            endcase
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++)
                send_item(($urandom_range(19) == 0) ? rand_word() : n, rand_word(),
                          (i == k - 1) ? 1'b1 : ($urandom_range(15) == 0));
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        @(negedge clk);
        start <= 1'b0;
        while (verdict_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        composite_flag = 1'b0;
        sender_idle_pct = 0;
        start = 1'b0;
        item = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        sender_idle_pct = 0;
        test_random(200);
        sender_idle_pct = 71;
        test_random(200);
        sender_idle_pct = 28;
        test_random(200);
        drain();

        if (errors == 0 && verdict_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
